FILE: rtl/cchd_pkg.sv
`default_nettype none
package cchd_pkg;

  localparam int ANG_FRAC     = 20;
  localparam int CORDIC_STEPS = 24;
  localparam int SQRT_STEPS   = 24;
  localparam int OUT_SHIFT    = 14;
  localparam int NORM_BITS    = 30;

  localparam logic [14:0] FULL_TURN = 15'd23040;
  localparam logic [28:0] ANG_90    = 29'(90) << ANG_FRAC;
  localparam logic [28:0] ANG_180   = 29'(180) << ANG_FRAC;
  localparam logic [28:0] ANG_360   = 29'(360) << ANG_FRAC;

  // APB register word indexes
  localparam logic [1:0] REG_OFS_X = 2'd0;
  localparam logic [1:0] REG_OFS_Y = 2'd1;
  localparam logic [1:0] REG_OFS_Z = 2'd2;

  typedef struct packed {
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } raw_t;

  typedef struct packed {
    logic signed [33:0] ex;
    logic signed [50:0] nx;
    logic [31:0]        aa;
    logic               degen;
  } vec_t;

  typedef struct packed {
    logic signed [33:0] ex;
    logic signed [50:0] nx;
    logic [23:0]        root;
    logic               degen;
  } sq_t;

  typedef struct packed {
    logic [14:0] heading;
    logic        degen;
  } res_t;

  typedef struct packed {
    logic degen;
    logic xneg;
    logic yneg;
    logic xz;
    logic yz;
  } flg_t;

  // atan(2^-i) in 2^-20 degree
  function automatic logic [26:0] atan_val(input logic [4:0] idx);
    logic [26:0] a;
    case (idx)
      5'd0:  a = 27'd47185920;
      5'd1:  a = 27'd27855475;
      5'd2:  a = 27'd14718068;
      5'd3:  a = 27'd7471121;
      5'd4:  a = 27'd3750058;
      5'd5:  a = 27'd1876857;
      5'd6:  a = 27'd938658;
      5'd7:  a = 27'd469357;
      5'd8:  a = 27'd234682;
      5'd9:  a = 27'd117342;
      5'd10: a = 27'd58671;
      5'd11: a = 27'd29335;
      5'd12: a = 27'd14668;
      5'd13: a = 27'd7334;
      5'd14: a = 27'd3667;
      5'd15: a = 27'd1833;
      5'd16: a = 27'd917;
      5'd17: a = 27'd458;
      5'd18: a = 27'd229;
      5'd19: a = 27'd115;
      5'd20: a = 27'd57;
      5'd21: a = 27'd29;
      5'd22: a = 27'd14;
      5'd23: a = 27'd7;
      default: a = 27'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/cchd_in_if.sv
`default_nettype none
interface cchd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mag_x;
  logic signed [15:0] mag_y;
  logic signed [15:0] mag_z;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;

  modport source (output valid, mag_x, mag_y, mag_z, accel_x, accel_y, accel_z,
                  input ready);
  modport sink (input valid, mag_x, mag_y, mag_z, accel_x, accel_y, accel_z,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/cchd_out_if.sv
`default_nettype none
interface cchd_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] heading;
  logic        degenerate;

  modport source (output valid, heading, degenerate, input ready);
  modport sink (input valid, heading, degenerate, output ready);
endinterface
`default_nettype wire

FILE: rtl/cchd_vec.sv
`default_nettype none
module cchd_vec (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cchd_pkg::raw_t     in_data,
  input  logic signed [15:0] ofs_x,
  input  logic signed [15:0] ofs_y,
  input  logic signed [15:0] ofs_z,
  output logic               out_valid,
  input  logic               out_ready,
  output cchd_pkg::vec_t     out_data
);

  logic [2:0] v;
  logic [2:0] en;

  // stage 1: offset correction
  logic signed [16:0] mx, my, mz;
  logic signed [15:0] ax, ay, az;
  // stage 2: East vector and squares
  logic signed [33:0] ex, ey, ez;
  logic signed [31:0] sqx, sqy, sqz;
  logic signed [15:0] ay2, az2;
  // stage 3
  cchd_pkg::vec_t     res;

  always_comb begin
    en[2] = !v[2] | out_ready;
    en[1] = !v[1] | en[2];
    en[0] = !v[0] | en[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mx <= 17'(in_data.mag_x) - 17'(ofs_x);
      my <= 17'(in_data.mag_y) - 17'(ofs_y);
      mz <= 17'(in_data.mag_z) - 17'(ofs_z);
      ax <= in_data.accel_x;
      ay <= in_data.accel_y;
      az <= in_data.accel_z;
    end
    if (en[1]) begin
      ex  <= 34'(my) * 34'(az) - 34'(mz) * 34'(ay);
      ey  <= 34'(mz) * 34'(ax) - 34'(mx) * 34'(az);
      ez  <= 34'(mx) * 34'(ay) - 34'(my) * 34'(ax);
      sqx <= 32'(ax) * 32'(ax);
      sqy <= 32'(ay) * 32'(ay);
      sqz <= 32'(az) * 32'(az);
      ay2 <= ay;
      az2 <= az;
    end
    if (en[2]) begin
      res.ex    <= ex;
      res.nx    <= 51'(ay2) * 51'(ez) - 51'(az2) * 51'(ey);
      res.aa    <= 32'(sqx) + 32'(sqy) + 32'(sqz);
      res.degen <= (ex == '0) && (ey == '0) && (ez == '0);
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[2];
  assign out_data  = res;

endmodule
`default_nettype wire

FILE: rtl/cchd_sqrt.sv
`default_nettype none
module cchd_sqrt (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cchd_pkg::vec_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cchd_pkg::sq_t  out_data
);

  localparam int NS = cchd_pkg::SQRT_STEPS;

  logic [NS-1:0]  v;
  logic [NS-1:0]  en;
  logic [23:0]    q [NS];
  logic [25:0]    r [NS];
  cchd_pkg::vec_t d [NS];

  always_comb begin
    en[NS-1] = !v[NS-1] | out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v[k] | en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // one root bit per stage, radicand is aa * 2^16
  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [23:0]    q_p;
    logic [25:0]    r_p;
    cchd_pkg::vec_t d_p;
    logic [47:0]    rad;
    logic [27:0]    cur;
    logic [27:0]    trial;

    if (k == 0) begin : g_first
      assign q_p = '0;
      assign r_p = '0;
      assign d_p = in_data;
    end else begin : g_next
      assign q_p = q[k-1];
      assign r_p = r[k-1];
      assign d_p = d[k-1];
    end

    assign rad   = {d_p.aa, 16'h0};
    assign cur   = {r_p, rad[47-2*k -: 2]};
    assign trial = {2'b00, q_p, 2'b01};

    always_ff @(posedge clk) begin
      if (en[k]) begin
        d[k] <= d_p;
        if (cur >= trial) begin
          r[k] <= 26'(cur - trial);
          q[k] <= {q_p[22:0], 1'b1};
        end else begin
          r[k] <= 26'(cur);
          q[k] <= {q_p[22:0], 1'b0};
        end
      end
    end
  end

  assign in_ready       = en[0];
  assign out_valid      = v[NS-1];
  assign out_data.ex    = d[NS-1].ex;
  assign out_data.nx    = d[NS-1].nx;
  assign out_data.root  = q[NS-1];
  assign out_data.degen = d[NS-1].degen;

endmodule
`default_nettype wire

FILE: rtl/cchd_cordic.sv
`default_nettype none
module cchd_cordic (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cchd_pkg::sq_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cchd_pkg::res_t out_data
);

  localparam int NC  = cchd_pkg::CORDIC_STEPS;
  localparam int NST = NC + 5;
  localparam int NB  = cchd_pkg::NORM_BITS;

  logic [NST-1:0]     v;
  logic [NST-1:0]     en;
  cchd_pkg::flg_t     fl [NST];

  logic signed [58:0] xv, yv;
  logic [58:0]        ux, uy;
  logic [58:0]        ux2, uy2;
  logic [4:0]         sh;
  logic [4:0]         sh_next;
  logic [29:0]        x0, y0;
  logic signed [33:0] cx [NC];
  logic signed [33:0] cy [NC];
  logic signed [27:0] cz [NC];
  cchd_pkg::res_t     res;

  logic [58:0]        mor;
  logic [26:0]        phi;
  logic [28:0]        theta;
  logic [14:0]        hd;

  always_comb begin
    en[NST-1] = !v[NST-1] | out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v[k] | en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // Y = Ex*|a|*256, X = Nx*256
  always_ff @(posedge clk) begin
    if (en[0]) begin
      yv    <= 59'(in_data.ex) * 59'($signed({1'b0, in_data.root}));
      xv    <= 59'(in_data.nx) <<< 8;
      fl[0] <= '{degen: in_data.degen, xneg: 1'b0, yneg: 1'b0, xz: 1'b0, yz: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ux    <= xv[58] ? 59'(-xv) : 59'(xv);
      uy    <= yv[58] ? 59'(-yv) : 59'(yv);
      fl[1] <= '{degen: fl[0].degen, xneg: xv[58], yneg: yv[58],
                 xz: (xv == '0), yz: (yv == '0)};
    end
  end

  // common right shift that brings both magnitudes below 2^30
  always_comb begin
    mor     = ux | uy;
    sh_next = '0;
    for (int b = NB; b < 59; b++) begin
      if (mor[b]) sh_next = 5'(b - NB + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sh    <= sh_next;
      ux2   <= ux;
      uy2   <= uy;
      fl[2] <= fl[1];
    end
    if (en[3]) begin
      x0    <= 30'(ux2 >> sh);
      y0    <= 30'(uy2 >> sh);
      fl[3] <= fl[2];
    end
  end

  for (genvar i = 0; i < NC; i++) begin : g_rot
    logic signed [33:0] xp, yp;
    logic signed [27:0] zp;
    logic signed [33:0] dx, dy;
    logic signed [27:0] at;

    if (i == 0) begin : g_first
      assign xp = $signed({4'b0, x0});
      assign yp = $signed({4'b0, y0});
      assign zp = '0;
    end else begin : g_next
      assign xp = cx[i-1];
      assign yp = cy[i-1];
      assign zp = cz[i-1];
    end

    assign dx = yp >>> i;
    assign dy = xp >>> i;
    assign at = $signed({1'b0, cchd_pkg::atan_val(5'(i))});

    always_ff @(posedge clk) begin
      if (en[4+i]) begin
        fl[4+i] <= fl[3+i];
        if (yp > 0) begin
          cx[i] <= xp + dx;
          cy[i] <= yp - dy;
          cz[i] <= zp + at;
        end else begin
          cx[i] <= xp - dx;
          cy[i] <= yp + dy;
          cz[i] <= zp - at;
        end
      end
    end
  end

  // clamp, quadrant map, scale to 1/64 degree
  always_comb begin
    if (fl[NST-2].yz) begin
      phi = '0;
    end else if (fl[NST-2].xz) begin
      phi = 27'(cchd_pkg::ANG_90);
    end else if (cz[NC-1] < 0) begin
      phi = '0;
    end else if (cz[NC-1] > $signed(28'(cchd_pkg::ANG_90))) begin
      phi = 27'(cchd_pkg::ANG_90);
    end else begin
      phi = 27'(cz[NC-1]);
    end

    if (!fl[NST-2].xneg && !fl[NST-2].yneg) begin
      theta = 29'(phi);
    end else if (fl[NST-2].xneg && !fl[NST-2].yneg) begin
      theta = cchd_pkg::ANG_180 - 29'(phi);
    end else if (fl[NST-2].xneg) begin
      theta = cchd_pkg::ANG_180 + 29'(phi);
    end else begin
      theta = cchd_pkg::ANG_360 - 29'(phi);
    end

    hd = theta[28:cchd_pkg::OUT_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      fl[NST-1] <= fl[NST-2];
      res.degen <= fl[NST-2].degen;
      if (fl[NST-2].degen || hd >= cchd_pkg::FULL_TURN) begin
        res.heading <= '0;
      end else begin
        res.heading <= hd;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NST-1];
  assign out_data  = res;

endmodule
`default_nettype wire

FILE: rtl/tilt_compensated_compass_heading.sv
`default_nettype none
// Tilt-compensated compass heading. Each beat on "in" carries one magnetometer
// and one accelerometer sample; each beat on "out" carries the heading of the
// forward axis in 1/64 degree (0..23039) and a flag for a zero East vector
// (heading then 0). A new sample is taken every clock cycle unless a stalled
// output has filled the pipeline. A sample passes through 3 vector-math
// stages, 24 square root stages, 4 scaling/normalize stages, 24 CORDIC stages
// and 1 output stage. Hard-iron offsets sit at APB byte addresses 0x0, 0x4,
// 0x8 (x, y, z; 16-bit signed in pwdata[15:0]) and should be written only
// while no sample is in flight.
module tilt_compensated_compass_heading (
  input  logic        clk,
  input  logic        rst,
  cchd_in_if.sink     in,
  cchd_out_if.source  out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic signed [15:0] ofs_x, ofs_y, ofs_z;
  logic               wr;

  cchd_pkg::raw_t     raw;
  logic               vec_valid, vec_ready;
  cchd_pkg::vec_t     vec_data;
  logic               sq_valid, sq_ready;
  cchd_pkg::sq_t      sq_data;
  cchd_pkg::res_t     res;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ofs_x <= '0;
      ofs_y <= '0;
      ofs_z <= '0;
    end else if (wr) begin
      case (paddr[3:2])
        cchd_pkg::REG_OFS_X: ofs_x <= pwdata[15:0];
        cchd_pkg::REG_OFS_Y: ofs_y <= pwdata[15:0];
        cchd_pkg::REG_OFS_Z: ofs_z <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      cchd_pkg::REG_OFS_X: prdata = {16'h0, ofs_x};
      cchd_pkg::REG_OFS_Y: prdata = {16'h0, ofs_y};
      cchd_pkg::REG_OFS_Z: prdata = {16'h0, ofs_z};
      default:             prdata = '0;
    endcase
  end

  assign raw.mag_x   = in.mag_x;
  assign raw.mag_y   = in.mag_y;
  assign raw.mag_z   = in.mag_z;
  assign raw.accel_x = in.accel_x;
  assign raw.accel_y = in.accel_y;
  assign raw.accel_z = in.accel_z;

  cchd_vec u_vec (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in.valid),
    .in_ready  (in.ready),
    .in_data   (raw),
    .ofs_x     (ofs_x),
    .ofs_y     (ofs_y),
    .ofs_z     (ofs_z),
    .out_valid (vec_valid),
    .out_ready (vec_ready),
    .out_data  (vec_data)
  );

  cchd_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vec_valid),
    .in_ready  (vec_ready),
    .in_data   (vec_data),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .out_data  (sq_data)
  );

  cchd_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .in_ready  (sq_ready),
    .in_data   (sq_data),
    .out_valid (out.valid),
    .out_ready (out.ready),
    .out_data  (res)
  );

  assign out.heading    = res.heading;
  assign out.degenerate = res.degen;

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.degenerate |-> out.heading == '0)
    else $error("degenerate result with nonzero heading");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> out.heading < cchd_pkg::FULL_TURN)
    else $error("heading out of range");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out.valid |-> in.ready)
    else $error("input stalled with empty output stage");

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
module tb_top;

  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int N_PHASES       = 6;
  localparam int ITEMS_PER_PHASE = 300;

  typedef enum logic [1:0] {
    IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
  } idle_mode_t;

  typedef struct {
    cchd_pkg::raw_t smp;
    bit             typed;
    cchd_pkg::res_t want;
  } dir_row_t;

  localparam longint ATAN_DEG[24] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  cchd_in_if  in_ch ();
  cchd_out_if out_ch ();

  tilt_compensated_compass_heading u_dut (
    .clk(clk), .rst(rst), .in(in_ch.sink), .out(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic signed [15:0] hard_iron [3];
  cchd_pkg::res_t heading_q [$];
  idle_mode_t idle_mode = IDLE_NONE;
  int         hold_cycles = 0;
  int         n_errors = 0, n_results = 0, n_degen = 0, n_sent = 0;
  longint     cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.mag_x, in_ch.mag_y, in_ch.mag_z} = '0;
    {in_ch.accel_x, in_ch.accel_y, in_ch.accel_z} = '0;
    out_ch.ready = 1'b0;
    foreach (hard_iron[i]) hard_iron[i] = '0;
  end

  function automatic cchd_pkg::res_t compass_predict(cchd_pkg::raw_t s);
    longint mx, my, mz, ax, ay, az, ex, ey, ez, nx, xv, yv, x, y, z, dx, dy, theta;
    longint unsigned v, root, bitv, ux, uy, hd;
    cchd_pkg::res_t o;
    mx = longint'(s.mag_x) - longint'(hard_iron[0]);
    my = longint'(s.mag_y) - longint'(hard_iron[1]);
    mz = longint'(s.mag_z) - longint'(hard_iron[2]);
    ax = s.accel_x; ay = s.accel_y; az = s.accel_z;
    ex = my * az - mz * ay;
    ey = mz * ax - mx * az;
    ez = mx * ay - my * ax;
    o.heading = '0;
    o.degen = 1'b0;
    if (ex == 0 && ey == 0 && ez == 0) begin
      o.degen = 1'b1;
      return o;
    end
    nx = ay * ez - az * ey;
    // |a| with 8 fraction bits
    v = longint'(ax * ax + ay * ay + az * az) << 16;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    yv = ex * longint'(root);
    xv = nx * 256;
    if (xv == 0 && yv == 0) return o;
    ux = xv < 0 ? -xv : xv;
    uy = yv < 0 ? -yv : yv;
    if (uy == 0) begin
      z = 0;
    end else if (ux == 0) begin
      z = longint'(cchd_pkg::ANG_90);
    end else begin
      while (ux >= (64'd1 << cchd_pkg::NORM_BITS) ||
             uy >= (64'd1 << cchd_pkg::NORM_BITS)) begin
        ux >>= 1;
        uy >>= 1;
      end
      x = ux; y = uy; z = 0;
      for (int i = 0; i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx; y -= dy; z += ATAN_DEG[i];
        end else begin
          x -= dx; y += dy; z -= ATAN_DEG[i];
        end
      end
      if (z < 0) z = 0;
      if (z > longint'(cchd_pkg::ANG_90)) z = longint'(cchd_pkg::ANG_90);
    end
    if (xv >= 0 && yv >= 0) theta = z;
    else if (xv < 0 && yv >= 0) theta = longint'(cchd_pkg::ANG_180) - z;
    else if (xv < 0) theta = longint'(cchd_pkg::ANG_180) + z;
    else theta = longint'(cchd_pkg::ANG_360) - z;
    hd = longint'(theta) >> cchd_pkg::OUT_SHIFT;
    if (hd >= cchd_pkg::FULL_TURN) hd = 0;
    o.heading = hd[14:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    n_errors++;
    $display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  // output monitor
  always @(posedge clk) begin
    cchd_pkg::res_t w;
    if (!rst) begin
      cycles++;
      if (cycles > TIMEOUT_CYCLES) begin
        $display("Timeout after %0d cycles", cycles);
        $display("Simulation FAILED");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (heading_q.size() == 0) begin
          report_mismatch("unexpected beat", out_ch.heading, -1);
        end else begin
          w = heading_q.pop_front();
          if (out_ch.heading !== w.heading)
            report_mismatch("heading", out_ch.heading, w.heading);
          if (out_ch.degenerate !== w.degen)
            report_mismatch("degenerate", out_ch.degenerate, w.degen);
          if (w.degen) n_degen++;
        end
      end
    end
  end

  // receiver backpressure; long holds counted here
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      case (idle_mode)
        IDLE_RECEIVER: out_ch.ready <= ($urandom_range(0, 99) >= 81);
        IDLE_BOTH:     out_ch.ready <= ($urandom_range(0, 99) >= 21);
        default:       out_ch.ready <= 1'b1;
      endcase
    end
  end

  task automatic write_offset(logic [1:0] idx, logic signed [15:0] val);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = {{16{val[15]}}, val};
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    hard_iron[idx] = val;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_sample(cchd_pkg::raw_t s, bit typed, cchd_pkg::res_t want);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SENDER) ? 81 : (idle_mode == IDLE_BOTH) ? 21 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    {in_ch.mag_x, in_ch.mag_y, in_ch.mag_z} = {s.mag_x, s.mag_y, s.mag_z};
    {in_ch.accel_x, in_ch.accel_y, in_ch.accel_z} = {s.accel_x, s.accel_y, s.accel_z};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (typed) begin
      if (want != compass_predict(s))
        report_mismatch("typed row vs predictor", want.heading, compass_predict(s).heading);
      heading_q.push_back(want);
    end else begin
      heading_q.push_back(compass_predict(s));
    end
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (heading_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic signed [15:0] pick_edge();
    case ($urandom_range(0, 4))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return -16'sd1;
      3: return 16'sd1;
      default: return 16'sd0;
    endcase
  endfunction

  function automatic cchd_pkg::raw_t random_sample();
    cchd_pkg::raw_t s;
    int kind;
    kind = $urandom_range(0, 9);
    s = cchd_pkg::raw_t'({$urandom, $urandom, $urandom});
    if (kind < 6) begin
      // plausible attitude: gravity mostly on one axis, modest field
      s.accel_x = $signed(16'($urandom_range(0, 12000))) - 16'sd6000;
      s.accel_y = $signed(16'($urandom_range(0, 12000))) - 16'sd6000;
      s.accel_z = $signed(16'($urandom_range(10000, 17000)));
      if ($urandom_range(0, 3) == 0) s.accel_z = -s.accel_z;
      s.mag_x = hard_iron[0] + $signed(16'($urandom_range(0, 6000))) - 16'sd3000;
      s.mag_y = hard_iron[1] + $signed(16'($urandom_range(0, 6000))) - 16'sd3000;
      s.mag_z = hard_iron[2] + $signed(16'($urandom_range(0, 6000))) - 16'sd3000;
    end else if (kind == 8) begin
      // corrected field parallel to gravity, or no gravity at all
      s.accel_x = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
      s.accel_y = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
      s.accel_z = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
      if ($urandom_range(0, 2) == 0) {s.accel_x, s.accel_y, s.accel_z} = '0;
      s.mag_x = hard_iron[0] + s.accel_x;
      s.mag_y = hard_iron[1] + s.accel_y;
      s.mag_z = hard_iron[2] + s.accel_z;
    end else if (kind == 9) begin
      s = '{pick_edge(), pick_edge(), pick_edge(), pick_edge(), pick_edge(), pick_edge()};
    end
    return s;
  endfunction

  dir_row_t dir_rows [$];

  task automatic add_row(int mx, int my, int mz, int ax, int ay, int az,
                         bit typed, int hd, bit dg);
    dir_row_t r;
    r.smp = '{16'(mx), 16'(my), 16'(mz), 16'(ax), 16'(ay), 16'(az)};
    r.typed = typed;
    r.want.heading = 15'(hd);
    r.want.degen = dg;
    dir_rows.push_back(r);
  endtask

  initial begin
    cchd_pkg::res_t none;
    logic signed [15:0] ofs_set [N_PHASES][3];
    none = '0;
    ofs_set[0] = '{16'sd0, 16'sd0, 16'sd0};
    ofs_set[1] = '{16'sd32767, -16'sd32767, 16'sd0};
    ofs_set[2] = '{-16'sd32767, 16'sd32767, 16'sd32767};
    ofs_set[3] = '{16'sd120, -16'sd340, 16'sd55};
    ofs_set[4] = '{-16'sd32767, -16'sd32767, -16'sd32767};
    ofs_set[5] = '{16'sd0, 16'sd0, 16'sd0};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: level board, cardinal headings, degenerate shapes, extremes
    add_row(0, 0, 0, 0, 0, 0, 1, 0, 1);
    add_row(100, 200, 300, 0, 0, 0, 1, 0, 1);
    add_row(300, 600, 900, 100, 200, 300, 1, 0, 1);
    add_row(0, 100, 0, 1000, 0, 0, 1, 0, 0);
    add_row(100, 0, 0, 0, 0, 1000, 1, 0, 0);
    add_row(0, 100, 0, 0, 0, 1000, 1, 5760, 0);
    add_row(-100, 0, 0, 0, 0, 1000, 1, 11520, 0);
    add_row(0, -100, 0, 0, 0, 1000, 1, 17280, 0);
    add_row(100, 100, 0, 0, 0, 1000, 0, 0, 0);
    add_row(-100, 100, 50, 0, 0, -1000, 0, 0, 0);
    add_row(-100, -100, 0, 300, 200, 1000, 0, 0, 0);
    add_row(100, -1, 0, 0, 0, 16384, 0, 0, 0);
    add_row(32767, 32767, 32767, 32767, 32767, 32767, 1, 0, 1);
    add_row(-32768, -32768, -32768, -32768, -32768, -32768, 1, 0, 1);
    add_row(32767, -32768, 32767, -32768, 32767, -32768, 0, 0, 0);
    add_row(-32768, 32767, -32768, 32767, 32767, -32768, 0, 0, 0);
    add_row(32767, 0, -32768, 0, -32768, 32767, 0, 0, 0);
    add_row(-32768, -32768, 0, 32767, 0, 32767, 0, 0, 0);
    add_row(1, 0, 0, 0, -1, 0, 0, 0, 0);
    add_row(0, 0, 1, 1, 1, 1, 0, 0, 0);
    foreach (dir_rows[i]) send_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      write_offset(cchd_pkg::REG_OFS_X, ofs_set[p][0]);
      write_offset(cchd_pkg::REG_OFS_Y, ofs_set[p][1]);
      write_offset(cchd_pkg::REG_OFS_Z, ofs_set[p][2]);
      idle_mode = idle_mode_t'(p % 4);
      if (p == 1) hold_cycles = 400;  // fill the pipe against a stalled sink
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_sample(random_sample(), 1'b0, none);
        if (p == 2 && k == ITEMS_PER_PHASE / 2) begin
          in_ch.valid = 1'b0;
          while (heading_q.size() != 0) @(negedge clk);
        end
      end
      drain();
    end

    $display("Sent %0d samples over %0d offset settings and 4 idle patterns",
             n_sent, N_PHASES + 1);
    $display("Checked %0d headings, %0d degenerate, %0d mismatches",
             n_results, n_degen, n_errors);
    if (n_errors == 0 && heading_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/cchd_pkg.sv
rtl/cchd_in_if.sv
rtl/cchd_out_if.sv
rtl/cchd_vec.sv
rtl/cchd_sqrt.sv
rtl/cchd_cordic.sv
rtl/tilt_compensated_compass_heading.sv
sim/tb_top.sv
